>>> rtl/core/mexp_pkg.sv
// ----------------------------------------------------------------------------
// Modular exponentiation package
// Shared widths, configuration register indexes and the core status type.
// ----------------------------------------------------------------------------
`default_nettype none

package mexp_pkg;

    localparam int MOD_WIDTH_DEF = 16;
    localparam int DATA_W        = 16;
    localparam int EXP_W         = 16;
    localparam int CFG_IDX_W     = 2;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MODULUS     = 2'd0,
        CFG_PUBLIC_EXP  = 2'd1,
        CFG_PRIVATE_EXP = 2'd2
    } t_cfg_idx;

    typedef struct packed {
        logic busy;
        logic done;
    } t_core_status;

endpackage

`default_nettype wire

>>> rtl/core/modular_exponentiation.sv
// ----------------------------------------------------------------------------
// Modular exponentiation
// Raises a value to the public or private exponent modulo a configured
// modulus, one request at a time, with a registered result stage.
// ----------------------------------------------------------------------------
//  Channel   Direction  Carries
//  s_axis    in         tdata: value; tuser: mode (1 selects private exponent)
//  m_axis    out        tdata: result
//  i_cfg     in         register writes: modulus, public and private exponent
//
//  A request reduces the value, then squares once for each exponent bit up to
//  the highest set bit and multiplies once for each set bit; each modular
//  product is formed bit-serially through the shared double-and-add unit.
//  A zero exponent or zero modulus goes straight from idle to the finish state.
//  Reset sets the modulus to 2 and both exponents to 1; there is no sweep.
//  A new request is taken while the previous result still waits downstream.
// ----------------------------------------------------------------------------
`default_nettype none

module modular_exponentiation
    import mexp_pkg::*;
#(
    parameter int MOD_WIDTH = MOD_WIDTH_DEF
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 s_axis_tvalid,
    output logic                      s_axis_tready,
    input  wire logic [DATA_W-1:0]    s_axis_tdata,  // [15:0] value
    input  wire logic                 s_axis_tuser,  // [0] mode
    output logic                      m_axis_tvalid,
    input  wire logic                 m_axis_tready,
    output logic      [DATA_W-1:0]    m_axis_tdata,  // [15:0] result
    input  wire logic                 i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  wire logic [DATA_W-1:0]    i_cfg_data
);

    logic [MOD_WIDTH-1:0] r_modulus;
    logic [EXP_W-1:0]     r_pub_exp;
    logic [EXP_W-1:0]     r_priv_exp;
    logic                 r_out_valid;
    logic [DATA_W-1:0]    r_out_data;

    t_core_status         status;
    logic [DATA_W-1:0]    core_result;
    logic                 start;
    logic                 hold;
    logic [EXP_W-1:0]     sel_exp;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_modulus  <= MOD_WIDTH'(2);
            r_pub_exp  <= EXP_W'(1);
            r_priv_exp <= EXP_W'(1);
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_MODULUS:     r_modulus  <= MOD_WIDTH'(i_cfg_data);
                CFG_PUBLIC_EXP:  r_pub_exp  <= i_cfg_data;
                CFG_PRIVATE_EXP: r_priv_exp <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    assign s_axis_tready = !status.busy;
    assign start         = s_axis_tvalid && s_axis_tready;
    assign sel_exp       = s_axis_tuser ? r_priv_exp : r_pub_exp;
    assign hold          = r_out_valid && !m_axis_tready;

    mexp_core #(
        .MOD_WIDTH(MOD_WIDTH)
    ) u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (start),
        .i_value  (s_axis_tdata),
        .i_exp    (sel_exp),
        .i_modulus(r_modulus),
        .i_hold   (hold),
        .o_status (status),
        .o_result (core_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (status.done) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
        if (status.done) begin
            r_out_data <= core_result;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

endmodule

`default_nettype wire

>>> rtl/core/mexp_modunit.sv
// ----------------------------------------------------------------------------
// Modular double-and-add unit
// Computes (2 * acc + addend) mod modulus for acc and addend below the
// modulus; the single arithmetic unit shared by every step of the core.
// ----------------------------------------------------------------------------
`default_nettype none

module mexp_modunit
    import mexp_pkg::*;
#(
    parameter int MOD_WIDTH = MOD_WIDTH_DEF
) (
    input  wire logic [MOD_WIDTH-1:0] i_acc,
    input  wire logic [MOD_WIDTH-1:0] i_addend,
    input  wire logic [MOD_WIDTH-1:0] i_modulus,
    output logic      [MOD_WIDTH-1:0] o_sum
);

    logic [MOD_WIDTH:0] dbl;
    logic [MOD_WIDTH:0] dbl_red;
    logic [MOD_WIDTH:0] sum;
    logic [MOD_WIDTH:0] modx;

    always_comb begin
        modx    = {1'b0, i_modulus};
        dbl     = {i_acc, 1'b0};
        dbl_red = (dbl >= modx) ? (dbl - modx) : dbl;
        sum     = {1'b0, dbl_red[MOD_WIDTH-1:0]} + {1'b0, i_addend};
        sum     = (sum >= modx) ? (sum - modx) : sum;
        o_sum   = sum[MOD_WIDTH-1:0];
    end

endmodule

`default_nettype wire

>>> rtl/core/mexp_core.sv
// ----------------------------------------------------------------------------
// Modular exponentiation sequencer
// Reduces the value, then runs right-to-left square-and-multiply, each
// modular product formed bit-serially through the shared double-and-add unit.
// ----------------------------------------------------------------------------
`default_nettype none

module mexp_core
    import mexp_pkg::*;
#(
    parameter int MOD_WIDTH = MOD_WIDTH_DEF
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_start,
    input  wire logic [DATA_W-1:0]    i_value,
    input  wire logic [EXP_W-1:0]     i_exp,
    input  wire logic [MOD_WIDTH-1:0] i_modulus,
    input  wire logic                 i_hold,
    output t_core_status              o_status,
    output logic      [DATA_W-1:0]    o_result
);

    localparam int SW = (MOD_WIDTH > DATA_W) ? MOD_WIDTH : DATA_W;
    localparam int CW = $clog2(SW + 1);

    typedef enum logic [4:0] {
        ST_IDLE     = 5'b00001,
        ST_REDUCE   = 5'b00010,
        ST_MUL_ACC  = 5'b00100,
        ST_MUL_BASE = 5'b01000,
        ST_FINISH   = 5'b10000
    } t_state;

    t_state               r_state, n_state;
    logic [MOD_WIDTH-1:0] r_base, n_base;
    logic [MOD_WIDTH-1:0] r_acc, n_acc;
    logic [MOD_WIDTH-1:0] r_prod, n_prod;
    logic [SW-1:0]        r_shift, n_shift;
    logic [CW-1:0]        r_cnt, n_cnt;
    logic [EXP_W-1:0]     r_exp, n_exp;

    logic [MOD_WIDTH-1:0] addend;
    logic [MOD_WIDTH-1:0] unit_sum;
    logic                 last_bit;

    mexp_modunit #(
        .MOD_WIDTH(MOD_WIDTH)
    ) u_unit (
        .i_acc    (r_prod),
        .i_addend (addend),
        .i_modulus(i_modulus),
        .o_sum    (unit_sum)
    );

    assign last_bit = (r_cnt == CW'(1));

    always_comb begin
        if (r_state == ST_REDUCE) begin
            addend = MOD_WIDTH'(r_shift[SW-1]);
        end else begin
            addend = r_shift[SW-1] ? r_base : '0;
        end
    end

    always_comb begin
        n_state = r_state;
        n_base  = r_base;
        n_acc   = r_acc;
        n_prod  = r_prod;
        n_shift = r_shift;
        n_cnt   = r_cnt;
        n_exp   = r_exp;
        case (r_state)
            ST_IDLE: begin
                if (i_start) begin
                    n_exp   = i_exp;
                    n_shift = SW'(i_value);
                    n_prod  = '0;
                    n_cnt   = CW'(SW);
                    if (i_exp == '0) begin
                        n_acc   = MOD_WIDTH'(1);
                        n_state = ST_FINISH;
                    end else if (i_modulus == '0) begin
                        n_acc   = '0;
                        n_state = ST_FINISH;
                    end else begin
                        n_acc   = (i_modulus == MOD_WIDTH'(1)) ? '0 : MOD_WIDTH'(1);
                        n_state = ST_REDUCE;
                    end
                end
            end
            ST_REDUCE, ST_MUL_ACC, ST_MUL_BASE: begin
                n_prod  = unit_sum;
                n_shift = {r_shift[SW-2:0], 1'b0};
                n_cnt   = r_cnt - CW'(1);
                if (last_bit) begin
                    n_prod = '0;
                    n_cnt  = CW'(SW);
                    if (r_state == ST_REDUCE) begin
                        n_base = unit_sum;
                        if (r_exp[0]) begin
                            n_shift = SW'(r_acc);
                            n_state = ST_MUL_ACC;
                        end else begin
                            n_shift = SW'(unit_sum);
                            n_state = ST_MUL_BASE;
                        end
                    end else if (r_state == ST_MUL_ACC) begin
                        n_acc   = unit_sum;
                        n_shift = SW'(r_base);
                        n_state = ST_MUL_BASE;
                    end else begin
                        n_base = unit_sum;
                        n_exp  = r_exp >> 1;
                        if (r_exp[EXP_W-1:1] == '0) begin
                            n_state = ST_FINISH;
                        end else if (r_exp[1]) begin
                            n_shift = SW'(r_acc);
                            n_state = ST_MUL_ACC;
                        end else begin
                            n_shift = SW'(unit_sum);
                            n_state = ST_MUL_BASE;
                        end
                    end
                end
            end
            ST_FINISH: begin
                if (!i_hold) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
        r_base  <= n_base;
        r_acc   <= n_acc;
        r_prod  <= n_prod;
        r_shift <= n_shift;
        r_cnt   <= n_cnt;
        r_exp   <= n_exp;
    end

    assign o_status.busy = (r_state != ST_IDLE);
    assign o_status.done = (r_state == ST_FINISH) && !i_hold;
    assign o_result      = DATA_W'(r_acc);

endmodule

`default_nettype wire

>>> tb/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Modular exponentiation testbench
// Drives requests of mode and value into the stream input. For each accepted
// request it works out the power modulo the configured modulus, from its own
// copy of the registers. Each result leaving the stream output is checked
// against the oldest outstanding prediction. A directed part covers the
// reset settings, field extremes, zero exponents, a modulus of zero or one
// and a key pair. A random part follows under several patterns of sender
// idling and receiver back-pressure, with fresh register settings in each.
// ----------------------------------------------------------------------------

module testbench;
    import mexp_pkg::*;

    localparam int CYCLE_LIMIT  = 4000000;
    localparam int SETTLE_CYCLES = 4;
    localparam int FINAL_CYCLES = 700;
    localparam int REPORT_LIMIT = 10;
    localparam int PHASE_ITEMS  = 125;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

    typedef struct {
        logic              mode;
        logic [DATA_W-1:0] value;
        logic [DATA_W-1:0] power;
    } t_power_req;

    logic              i_clk;
    logic              i_rst_n;
    logic              s_axis_tvalid;
    logic              s_axis_tready;
    logic [DATA_W-1:0] s_axis_tdata;
    logic              s_axis_tuser;
    logic              m_axis_tvalid;
    logic              m_axis_tready = 1'b0;
    logic [DATA_W-1:0] m_axis_tdata;
    logic              i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_idx;
    logic [DATA_W-1:0] i_cfg_data;

    logic [DATA_W-1:0] modulus_copy;
    logic [EXP_W-1:0]  public_exp_copy;
    logic [EXP_W-1:0]  private_exp_copy;

    t_power_req pending_powers[$];
    int         mismatch_count = 0;
    int         cycle_count = 0;
    int         send_idle_pct;
    int         recv_stall_pct;

    modular_exponentiation DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),   // [15:0] value
        .s_axis_tuser  (s_axis_tuser),   // [0] mode
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),   // [15:0] result
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data)
    );

    always begin
        i_clk = 1'b0;
        #6;
        i_clk = 1'b1;
        #6;
    end

    function automatic logic [DATA_W-1:0] power_mod(input logic [DATA_W-1:0] base,
                                                    input logic [EXP_W-1:0] exponent,
                                                    input logic [DATA_W-1:0] modulus);
        longint unsigned b;
        longint unsigned r;
        longint unsigned m;
        logic [EXP_W-1:0] e;
        if (exponent == '0) return 16'd1;
        if (modulus == '0) return 16'd0;
        m = modulus;
        b = base % m;
        r = 1 % m;
        e = exponent;
        while (e != '0) begin
            if (e[0]) r = (r * b) % m;
            b = (b * b) % m;
            e = e >> 1;
        end
        return r[DATA_W-1:0];
    endfunction

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("testbench: done, errors");
            $finish;
        end
    end

    always @(negedge i_clk) begin
        m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    always @(posedge i_clk) begin
        t_power_req oldest;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (pending_powers.size() == 0) begin
                if (mismatch_count < REPORT_LIMIT)
                    $display("unexpected result %0d at cycle %0d", m_axis_tdata, cycle_count);
                mismatch_count++;
            end else begin
                oldest = pending_powers.pop_front();
                if (m_axis_tdata !== oldest.power) begin
                    if (mismatch_count < REPORT_LIMIT)
                        $display("mismatch: mode %0d value %0d expected %0d actual %0d",
                                 oldest.mode, oldest.value, oldest.power, m_axis_tdata);
                    mismatch_count++;
                end
            end
        end
    end

    task automatic send_request(input logic mode, input logic [DATA_W-1:0] value);
        t_power_req req;
        while ($urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= value;
        s_axis_tuser  <= mode;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        req.mode  = mode;
        req.value = value;
        req.power = power_mod(value, mode ? private_exp_copy : public_exp_copy, modulus_copy);
        pending_powers.insert(pending_powers.size(), req);
        @(negedge i_clk);
    endtask

    task automatic wait_idle();
        s_axis_tvalid <= 1'b0;
        while (pending_powers.size() != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    // The spare index has no register behind it, so its write must change nothing.
    task automatic configure(input logic [DATA_W-1:0] modulus,
                             input logic [EXP_W-1:0] public_exp,
                             input logic [EXP_W-1:0] private_exp);
        wait_idle();
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= CFG_MODULUS;
        i_cfg_data <= modulus;
        @(negedge i_clk);
        i_cfg_idx  <= CFG_PUBLIC_EXP;
        i_cfg_data <= public_exp;
        @(negedge i_clk);
        i_cfg_idx  <= CFG_PRIVATE_EXP;
        i_cfg_data <= private_exp;
        @(negedge i_clk);
        i_cfg_idx  <= CFG_SPARE;
        i_cfg_data <= DATA_W'($urandom);
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        modulus_copy     = modulus;
        public_exp_copy  = public_exp;
        private_exp_copy = private_exp;
    endtask

    task automatic test_reset_settings();
        send_request(1'b0, 16'd3);
        send_request(1'b1, 16'd65535);
        send_request(1'b0, 16'd0);
    endtask

    task automatic test_field_extremes();
        configure(16'd65535, 16'd65535, 16'd65535);
        send_request(1'b0, 16'd0);
        send_request(1'b1, 16'd1);
        send_request(1'b0, 16'd65535);
        send_request(1'b1, 16'd65534);
        send_request(1'b0, 16'h5555);
        send_request(1'b1, 16'hAAAA);
        configure(16'd2, 16'd1, 16'd2);
        send_request(1'b0, 16'd65535);
        send_request(1'b1, 16'd65535);
    endtask

    task automatic test_zero_exponent();
        configure(16'd0, 16'd0, 16'd0);
        send_request(1'b0, 16'd7);
        send_request(1'b1, 16'd0);
        configure(16'd1, 16'd0, 16'd5);
        send_request(1'b0, 16'd65535);
        send_request(1'b1, 16'd9);
    endtask

    task automatic test_degenerate_modulus();
        configure(16'd0, 16'd3, 16'd65535);
        send_request(1'b0, 16'd12345);
        send_request(1'b1, 16'd2);
        configure(16'd1, 16'd1, 16'd40000);
        send_request(1'b0, 16'd1);
        send_request(1'b1, 16'd65535);
    endtask

    task automatic test_key_pair();
        configure(16'd3233, 16'd17, 16'd2753);
        send_request(1'b0, 16'd65);
        send_request(1'b1, 16'd2790);
        send_request(1'b0, 16'd3233);
        send_request(1'b1, 16'd60000);
    endtask

    function automatic logic [EXP_W-1:0] pick_exponent();
        case ($urandom_range(9))
            0: return '0;
            1: return 16'd65535;
            2: return 16'd1;
            default: return EXP_W'($urandom);
        endcase
    endfunction

    function automatic logic [DATA_W-1:0] pick_modulus();
        case ($urandom_range(11))
            0: return 16'd65535;
            1: return 16'd2;
            2: return 16'd1;
            3: return 16'd0;
            default: return DATA_W'($urandom_range(65535, 2));
        endcase
    endfunction

    task automatic test_random_traffic(input int idle_pct, input int stall_pct);
        wait_idle();
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        repeat (2) begin
            configure(pick_modulus(), pick_exponent(), pick_exponent());
            repeat (PHASE_ITEMS / 2) send_request(1'($urandom), DATA_W'($urandom));
        end
    endtask

    initial begin
        i_rst_n          = 1'b0;
        s_axis_tvalid    = 1'b0;
        s_axis_tdata     = '0;
        s_axis_tuser     = 1'b0;
        i_cfg_we         = 1'b0;
        i_cfg_idx        = CFG_MODULUS;
        i_cfg_data       = '0;
        send_idle_pct    = 0;
        recv_stall_pct   = 0;
        modulus_copy     = 16'd2;
        public_exp_copy  = 16'd1;
        private_exp_copy = 16'd1;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_reset_settings();
        test_field_extremes();
        test_zero_exponent();
        test_degenerate_modulus();
        test_key_pair();
        test_random_traffic(0, 0);
        test_random_traffic(77, 0);
        test_random_traffic(0, 77);
        test_random_traffic(27, 27);
        test_random_traffic(0, 0);
        test_random_traffic(77, 0);
        test_random_traffic(0, 77);
        test_random_traffic(27, 27);

        wait_idle();
        repeat (FINAL_CYCLES) @(negedge i_clk);
        if (mismatch_count == 0) begin
            $display("testbench: done, clean");
        end else begin
            $display("testbench: done, errors");
        end
        $finish;
    end

endmodule

>>> files.f
rtl/core/mexp_pkg.sv
rtl/core/mexp_modunit.sv
rtl/core/mexp_core.sv
rtl/core/modular_exponentiation.sv
tb/testbench.sv
